// ===== rtl/gif_lzw_index_decoder_core_defines.svh =====
// Assertion macros
`ifndef GIF_LZW_INDEX_DECODER_CORE_DEFINES_SVH
`define GIF_LZW_INDEX_DECODER_CORE_DEFINES_SVH
`define GLD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define GLD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`endif

// ===== rtl/gld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;
  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned DictDepth = 4096;

  typedef enum logic [2:0] {
    ST_INDEX = 3'd0, ST_NEED = 3'd1, ST_END = 3'd2, ST_ERR = 3'd3,
    ST_BYTE_OK = 3'd4, ST_BYTE_FULL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_AWAIT_CLEAR = 2'd0, PH_AWAIT_FIRST = 2'd1, PH_DECODING = 2'd2, PH_ENDED = 2'd3
  } phase_e;

  localparam logic OpPush = 1'b0;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic [2:0] status;
  } out_item_t;

  // datapath commands
  typedef struct packed {
    logic restart;   // full restart
    logic push;      // push byte
    logic take;      // take code from bit buffer, classify
    logic walk;      // one step of prefix walk
    logic pop_req;   // issue stack read
    logic emit;      // present result
    logic [2:0] emit_status;
    logic emit_pix;  // pixel from stack read data
  } cmd_t;

  typedef struct packed {
    logic stack_nonempty;
    logic ended;
    logic buf_full;
    logic have_code;
    logic code_is_clear;
    logic code_is_end;
    logic code_err;    // code error given phase
    logic code_await;  // phase await clear (non-clear non-end = error, phase kept)
    logic walk_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/gif_lzw_index_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// GIF LZW index decoder. A transaction is taken when start_i is high, busy_o low and no APB
// write to address 0 comes in the same cycle. A push, or a pull after the end code, gives its
// result strobe in the cycle right after acceptance. A pull that pops a pending index strobes
// through the stack memory read, via the S_POP and S_EMIT states. A pull that takes a new code
// walks the prefix links in S_WALK (one dictionary read and one stack write per link), then
// pops through S_POP and S_EMIT; need-byte, end and error are emitted from S_DECODE. Each clear
// code read in the same pull keeps the controller in S_DECODE. busy_o stays high until the strobe.
// result_valid_o strobes for one cycle; the receiver cannot stall it, so it must take every result.
// APB writes to address 0 restart the decoder.
module gif_lzw_index_decoder_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire gld_pkg::in_item_t   item_i,
  output logic                     busy_o,
  output logic                     result_valid_o,
  output gld_pkg::out_item_t       result_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic                paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic [3:0] mcs_q, mcs_d;
  logic cfg_wr;
  gld_pkg::cmd_t cmd;
  gld_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr;
  assign prdata = paddr ? 32'd0 : {28'd0, mcs_q};
  // restart sees the value being written
  assign mcs_d = cfg_wr ? pwdata[3:0] : mcs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mcs_q <= 4'd8;
    else mcs_q <= mcs_d;
  end

  gld_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .opcode_i(item_i.opcode), .cfg_wr_i(cfg_wr),
    .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  gld_datapath u_dp (
    .clk_i, .rst_ni, .min_code_size_i(mcs_d), .data_byte_i(item_i.data_byte),
    .cmd_i(cmd), .stat_o(stat), .result_o, .result_valid_o
  );
endmodule
`default_nettype wire

// ===== rtl/gld_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gld_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [3:0]         min_code_size_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire gld_pkg::cmd_t      cmd_i,
  output gld_pkg::stat_t          stat_o,
  output gld_pkg::out_item_t      result_o,
  output logic                    result_valid_o
);
  logic [19:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [3:0]  cw_q, cw_d;
  logic [12:0] nfc_q, nfc_d;
  logic [11:0] prev_q, prev_d;
  logic [7:0]  pfi_q, pfi_d;
  logic [12:0] sp_q, sp_d;
  gld_pkg::phase_e ph_q, ph_d;
  // walk state
  logic [11:0] wc_q, wc_d;
  logic [11:0] code_q, code_d;
  logic [12:0] guard_q, guard_d;
  logic        walking_q, walking_d;
  logic        rd_pend_q;
  logic        valid_q;
  gld_pkg::out_item_t res_q, res_d;

  logic [11:0] prefix_mem [gld_pkg::DictDepth];
  logic [7:0]  suffix_mem [gld_pkg::DictDepth];
  logic [7:0]  stack_mem  [gld_pkg::DictDepth+1];
  logic [11:0] pre_rd_q;
  logic [7:0]  suf_rd_q;
  logic [7:0]  stk_rd_q;

  logic [3:0]  esz;
  logic [8:0]  clr;
  logic [11:0] code;
  logic        in_chain;
  logic        st_wr;
  logic [12:0] st_wa;
  logic [7:0]  st_wd;
  logic        dict_wr;
  logic        dict_rd;

  always_comb begin
    esz = min_code_size_i;
    if (esz < 4'd2) esz = 4'd2;
    if (esz > 4'd8) esz = 4'd8;
    clr = 9'd1 << esz;
    code = 12'(buf_q & ((20'd1 << cw_q) - 20'd1));
  end

  // chain link test on current walk code
  assign in_chain = ({1'b0, wc_q} > {4'd0, clr} + 13'd1) && (guard_q < 13'(gld_pkg::DictDepth));

  always_comb begin
    stat_o.stack_nonempty = (sp_q != '0);
    stat_o.ended = (ph_q == gld_pkg::PH_ENDED);
    stat_o.buf_full = (cnt_q > 5'd12);
    stat_o.have_code = ({1'b0, cnt_q} >= {2'b0, cw_q});
    stat_o.code_is_clear = ({3'b0, code} == {6'b0, clr});
    stat_o.code_is_end = ({3'b0, code} == {6'b0, clr} + 15'd1);
    stat_o.code_await = (ph_q == gld_pkg::PH_AWAIT_CLEAR);
    stat_o.code_err = (ph_q == gld_pkg::PH_AWAIT_FIRST) ? ({3'b0, code} >= {6'b0, clr}) :
                      ({1'b0, code} > nfc_q) ||
                      ({1'b0, code} == nfc_q && nfc_q >= 13'(gld_pkg::DictDepth));
    stat_o.walk_done = !walking_q && !rd_pend_q;
  end

  always_comb begin
    buf_d = buf_q; cnt_d = cnt_q; cw_d = cw_q; nfc_d = nfc_q;
    prev_d = prev_q; pfi_d = pfi_q; sp_d = sp_q; ph_d = ph_q;
    wc_d = wc_q; code_d = code_q; guard_d = guard_q; walking_d = walking_q;
    st_wr = 1'b0; st_wa = sp_q; st_wd = '0; dict_wr = 1'b0; dict_rd = 1'b0;
    res_d = res_q;
    if (cmd_i.restart) begin
      buf_d = '0; cnt_d = '0; prev_d = '0; pfi_d = '0; sp_d = '0;
      ph_d = gld_pkg::PH_AWAIT_CLEAR; cw_d = esz + 4'd1; nfc_d = {4'd0, clr} + 13'd2;
      walking_d = 1'b0;
    end else if (cmd_i.push) begin
      buf_d = buf_q | 20'({12'd0, data_byte_i} << cnt_q);
      cnt_d = cnt_q + 5'd8;
    end else if (cmd_i.take) begin
      buf_d = buf_q >> cw_q;
      cnt_d = cnt_q - {1'b0, cw_q};
      if (stat_o.code_is_clear) begin
        cw_d = esz + 4'd1; nfc_d = {4'd0, clr} + 13'd2; ph_d = gld_pkg::PH_AWAIT_FIRST;
      end else if (stat_o.code_is_end) begin
        ph_d = gld_pkg::PH_ENDED;
      end else if (stat_o.code_await) begin
        ph_d = ph_q;
      end else if (stat_o.code_err) begin
        ph_d = gld_pkg::PH_AWAIT_CLEAR;
      end else if (ph_q == gld_pkg::PH_AWAIT_FIRST) begin
        st_wr = 1'b1; st_wd = code[7:0]; sp_d = sp_q + 13'd1;
        prev_d = code; pfi_d = code[7:0]; ph_d = gld_pkg::PH_DECODING;
      end else begin
        code_d = code; guard_d = '0; walking_d = 1'b1;
        if ({1'b0, code} == nfc_q) begin
          st_wr = 1'b1; st_wd = pfi_q; sp_d = sp_q + 13'd1; wc_d = prev_q;
        end else begin
          wc_d = code;
        end
      end
    end else if (cmd_i.walk) begin
      if (rd_pend_q) begin
        st_wr = 1'b1; st_wd = suf_rd_q; sp_d = sp_q + 13'd1; wc_d = pre_rd_q;
        guard_d = guard_q + 13'd1;
      end else if (walking_q) begin
        if (in_chain) begin
          dict_rd = 1'b1;
        end else begin
          st_wr = 1'b1; st_wd = wc_q[7:0]; sp_d = sp_q + 13'd1; walking_d = 1'b0;
          if (nfc_q < 13'(gld_pkg::DictDepth)) begin
            dict_wr = 1'b1;
            nfc_d = nfc_q + 13'd1;
            if (nfc_q + 13'd1 == (13'd1 << cw_q) && cw_q < 4'(gld_pkg::MaxCodeBits))
              cw_d = cw_q + 4'd1;
          end
          prev_d = code_q; pfi_d = wc_q[7:0];
        end
      end
    end else if (cmd_i.pop_req) begin
      sp_d = sp_q - 13'd1;
    end
    if (cmd_i.emit) begin
      res_d.status = cmd_i.emit_status;
      res_d.pixel_index = cmd_i.emit_pix ? stk_rd_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_wr) stack_mem[st_wa] <= st_wd;
    if (cmd_i.pop_req) stk_rd_q <= stack_mem[sp_q - 13'd1];
    if (dict_wr) begin
      prefix_mem[nfc_q[11:0]] <= prev_q;
      suffix_mem[nfc_q[11:0]] <= wc_q[7:0];
    end
    if (dict_rd) begin
      pre_rd_q <= prefix_mem[wc_q];
      suf_rd_q <= suffix_mem[wc_q];
    end
    wc_q <= wc_d; code_q <= code_d; guard_q <= guard_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0; cw_q <= 4'd9; nfc_q <= 13'd258; prev_q <= '0; pfi_q <= '0;
      sp_q <= '0; ph_q <= gld_pkg::PH_AWAIT_CLEAR; walking_q <= 1'b0;
      rd_pend_q <= 1'b0; valid_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d; cw_q <= cw_d; nfc_q <= nfc_d; prev_q <= prev_d; pfi_q <= pfi_d;
      sp_q <= sp_d; ph_q <= ph_d; walking_q <= walking_d;
      rd_pend_q <= dict_rd;
      valid_q <= cmd_i.emit;
    end
  end

  assign result_o = res_q;
  assign result_valid_o = valid_q;
endmodule
`default_nettype wire

// ===== rtl/gld_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gld_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              opcode_i,
  input  wire logic              cfg_wr_i,
  input  wire gld_pkg::stat_t    stat_i,
  output gld_pkg::cmd_t          cmd_o,
  output logic                   busy_o
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_DECODE = 5'b00010, S_WALK = 5'b00100,
    S_POP = 5'b01000, S_EMIT = 5'b10000
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.restart = cfg_wr_i;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !cfg_wr_i) begin
          if (opcode_i == gld_pkg::OpPush) begin
            cmd_o.push = !stat_i.buf_full;
            cmd_o.emit = 1'b1;
            cmd_o.emit_status = stat_i.buf_full ? gld_pkg::ST_BYTE_FULL : gld_pkg::ST_BYTE_OK;
          end else if (stat_i.stack_nonempty) begin
            cmd_o.pop_req = 1'b1; state_d = S_POP;
          end else if (stat_i.ended) begin
            cmd_o.emit = 1'b1; cmd_o.emit_status = gld_pkg::ST_END;
          end else begin
            state_d = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        if (!stat_i.have_code) begin
          cmd_o.emit = 1'b1; cmd_o.emit_status = gld_pkg::ST_NEED; state_d = S_IDLE;
        end else begin
          cmd_o.take = 1'b1;
          if (stat_i.code_is_clear) state_d = S_DECODE;
          else if (stat_i.code_is_end) begin
            cmd_o.emit = 1'b1; cmd_o.emit_status = gld_pkg::ST_END; state_d = S_IDLE;
          end else if (stat_i.code_await || stat_i.code_err) begin
            cmd_o.emit = 1'b1; cmd_o.emit_status = gld_pkg::ST_ERR; state_d = S_IDLE;
          end else state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          cmd_o.pop_req = 1'b1; state_d = S_POP;
        end else cmd_o.walk = 1'b1;
      end
      S_POP: state_d = S_EMIT;
      S_EMIT: begin
        cmd_o.emit = 1'b1; cmd_o.emit_pix = 1'b1;
        cmd_o.emit_status = gld_pkg::ST_INDEX; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/gld_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "gif_lzw_index_decoder_core_defines.svh"
module gld_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic result_valid_o,
  input wire logic [2:0] status
);
  `GLD_ASSERT(a_status_range, clk_i, rst_ni, result_valid_o |-> status <= 3'd5)
  `GLD_ASSERT(a_accept_answers, clk_i, rst_ni, (start_i && !busy_o) |=> (result_valid_o || busy_o))
  `GLD_ASSERT(a_busy_ends_result, clk_i, rst_ni, $fell(busy_o) |-> result_valid_o)
  `GLD_ASSERT(a_valid_not_busy, clk_i, rst_ni, result_valid_o |-> !busy_o)
  `GLD_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !result_valid_o)
endmodule
bind gif_lzw_index_decoder_core gld_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .result_valid_o, .status(result_o.status)
);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i = 1'b0;
  gld_pkg::in_item_t item_i = '0;
  logic busy_o, result_valid_o;
  gld_pkg::out_item_t result_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam int RegMinCodeSize = 0;

  gif_lzw_index_decoder_core dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("gif_lzw_index_decoder_core regression: fail");
    $finish;
  end

  function automatic int clamp_size(int s);
    if (s < 2) return 2;
    if (s > 8) return 8;
    return s;
  endfunction

  class pixel_scoreboard;
    gld_pkg::out_item_t expected_q[$];
    int mismatches;
    int size_reg;
    int buf_bits, buf_cnt, width, next_free, prev_code, prev_first, depth;
    gld_pkg::phase_e phase;
    logic [11:0] prefix_mem[gld_pkg::DictDepth];
    logic [7:0] suffix_mem[gld_pkg::DictDepth];
    logic [7:0] pix_stack[gld_pkg::DictDepth + 1];

    function new();
      size_reg = 8;
      restart();
    endfunction

    function void reset_table();
      width = clamp_size(size_reg) + 1;
      next_free = (1 << clamp_size(size_reg)) + 2;
    endfunction

    function void restart();
      buf_bits = 0; buf_cnt = 0; prev_code = 0; prev_first = 0; depth = 0;
      phase = gld_pkg::PH_AWAIT_CLEAR;
      reset_table();
    endfunction

    function void write_size(int v);
      size_reg = v & 15;
      restart();
    endfunction

    function void stack_push(int v);
      if (depth < gld_pkg::DictDepth + 1) begin
        pix_stack[depth] = v[7:0];
        depth++;
      end
    endfunction

    function int unroll(int c, int clr);
      int guard;
      guard = 0;
      while (c > clr + 1 && c < gld_pkg::DictDepth && guard < gld_pkg::DictDepth) begin
        stack_push(suffix_mem[c]);
        c = prefix_mem[c];
        guard++;
      end
      c &= 8'hFF;
      stack_push(c);
      return c;
    endfunction

    function gld_pkg::out_item_t decode(gld_pkg::in_item_t it);
      int clr, code, first;
      gld_pkg::status_e st;
      logic [7:0] pix;
      gld_pkg::out_item_t r;
      clr = 1 << clamp_size(size_reg);
      st = gld_pkg::ST_INDEX;
      pix = '0;
      if (it.opcode == gld_pkg::OpPush) begin
        if (buf_cnt + 8 > 20) st = gld_pkg::ST_BYTE_FULL;
        else begin
          buf_bits = (buf_bits | (int'(it.data_byte) << buf_cnt)) & 20'hFFFFF;
          buf_cnt += 8;
          st = gld_pkg::ST_BYTE_OK;
        end
      end else if (depth > 0) begin
        depth--;
        pix = pix_stack[depth];
      end else if (phase == gld_pkg::PH_ENDED) begin
        st = gld_pkg::ST_END;
      end else begin
        while (1) begin
          if (buf_cnt < width) begin st = gld_pkg::ST_NEED; break; end
          code = buf_bits & ((1 << width) - 1);
          buf_bits >>= width;
          buf_cnt -= width;
          if (code == clr) begin
            reset_table();
            phase = gld_pkg::PH_AWAIT_FIRST;
            continue;
          end
          if (code == clr + 1) begin phase = gld_pkg::PH_ENDED; st = gld_pkg::ST_END; break; end
          if (phase == gld_pkg::PH_AWAIT_CLEAR) begin st = gld_pkg::ST_ERR; break; end
          if (phase == gld_pkg::PH_AWAIT_FIRST) begin
            if (code >= clr) begin
              phase = gld_pkg::PH_AWAIT_CLEAR; st = gld_pkg::ST_ERR; break;
            end
            stack_push(code);
            prev_code = code;
            prev_first = code;
            phase = gld_pkg::PH_DECODING;
          end else begin
            if (code < next_free) first = unroll(code, clr);
            else if (code == next_free && next_free < gld_pkg::DictDepth) begin
              stack_push(prev_first);
              first = unroll(prev_code, clr);
            end else begin
              phase = gld_pkg::PH_AWAIT_CLEAR; st = gld_pkg::ST_ERR; break;
            end
            if (next_free < gld_pkg::DictDepth) begin
              prefix_mem[next_free] = prev_code[11:0];
              suffix_mem[next_free] = first[7:0];
              next_free++;
              if (next_free == (1 << width) && width < gld_pkg::MaxCodeBits) width++;
            end
            prev_code = code & 12'hFFF;
            prev_first = first;
          end
          depth--;
          pix = pix_stack[depth];
          break;
        end
      end
      r.status = st;
      r.pixel_index = (st == gld_pkg::ST_INDEX) ? pix : 8'h00;
      return r;
    endfunction

    function void note(gld_pkg::in_item_t it);
      expected_q = {expected_q, decode(it)};
    endfunction

    function void check(gld_pkg::out_item_t got);
      gld_pkg::out_item_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result idx=%0d st=%0d",
                                        got.pixel_index, got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status || got.pixel_index !== exp_r.pixel_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected idx=%0d st=%0d, got idx=%0d st=%0d",
                   exp_r.pixel_index, exp_r.status, got.pixel_index, got.status);
      end
    endfunction
  endclass

  pixel_scoreboard sb = new();

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check(result_o);
  end

  // code stream builder, tracks the width the decoder will use
  bit code_bits[$];
  logic [7:0] byte_q[$];
  int gen_w, gen_nf, gen_clr;
  gld_pkg::phase_e gen_ph;
  int burst_left = 0;

  task automatic gen_start(int s);
    gen_clr = 1 << clamp_size(s);
    gen_w = clamp_size(s) + 1;
    gen_nf = gen_clr + 2;
    gen_ph = gld_pkg::PH_AWAIT_CLEAR;
    code_bits.delete();
    byte_q.delete();
  endtask

  task automatic put_code(int c);
    for (int i = 0; i < gen_w; i++) code_bits = {code_bits, c[i]};
    if (c == gen_clr) begin
      gen_w = clamp_size($clog2(gen_clr)) + 1;
      gen_nf = gen_clr + 2;
      gen_ph = gld_pkg::PH_AWAIT_FIRST;
    end else if (c == gen_clr + 1) gen_ph = gld_pkg::PH_ENDED;
    else if (gen_ph == gld_pkg::PH_AWAIT_FIRST)
      gen_ph = (c >= gen_clr) ? gld_pkg::PH_AWAIT_CLEAR : gld_pkg::PH_DECODING;
    else if (gen_ph == gld_pkg::PH_DECODING) begin
      if (c < gen_nf || (c == gen_nf && gen_nf < gld_pkg::DictDepth)) begin
        if (gen_nf < gld_pkg::DictDepth) begin
          gen_nf++;
          if (gen_nf == (1 << gen_w) && gen_w < gld_pkg::MaxCodeBits) gen_w++;
        end
      end else gen_ph = gld_pkg::PH_AWAIT_CLEAR;
    end
  endtask

  task automatic gen_random(int ncodes, int root_pct);
    int r;
    for (int n = 0; n < ncodes && gen_ph != gld_pkg::PH_ENDED; n++) begin
      r = $urandom_range(0, 99);
      if (gen_ph != gld_pkg::PH_DECODING) begin
        if (gen_ph == gld_pkg::PH_AWAIT_FIRST && r < 95)
          put_code($urandom_range(0, gen_clr - 1));
        else if (r < 97) put_code(gen_clr);
        else put_code($urandom_range(0, (1 << gen_w) - 1));
      end else if (r < root_pct) put_code($urandom_range(0, gen_clr - 1));
      else if (r < root_pct + 5 && gen_nf < gld_pkg::DictDepth) put_code(gen_nf);
      else if (r < root_pct + 7) put_code(gen_clr);
      else if (r < root_pct + 9) put_code($urandom_range(0, (1 << gen_w) - 1));
      else if (gen_nf > gen_clr + 2) put_code($urandom_range(gen_clr + 2, gen_nf - 1));
      else put_code($urandom_range(0, gen_clr - 1));
    end
    if (gen_ph != gld_pkg::PH_ENDED) put_code(gen_clr + 1);
  endtask

  task automatic pack_bytes();
    logic [7:0] b;
    while (code_bits.size() > 0) begin
      b = '0;
      for (int i = 0; i < 8; i++) if (code_bits.size() > 0) b[i] = code_bits.pop_front();
      byte_q = {byte_q, b};
    end
  endtask

  task automatic send(gld_pkg::in_item_t it);
    bit ok;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    item_i <= it;
    do begin
      @(negedge clk_i);
      ok = !busy_o;
      @(posedge clk_i);
    end while (!ok);
    sb.note(it);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic pull();
    gld_pkg::in_item_t it;
    it.opcode = ~gld_pkg::OpPush;
    it.data_byte = 8'($urandom);
    send(it);
  endtask

  task automatic run_stream(int pause_at);
    gld_pkg::in_item_t it;
    int n;
    n = 0;
    while (byte_q.size() > 0) begin
      if (sb.phase == gld_pkg::PH_ENDED && sb.depth == 0 && sb.buf_cnt > 12) byte_q.delete();
      else if (sb.buf_cnt <= 12 || $urandom_range(0, 9) == 0) begin
        it.opcode = gld_pkg::OpPush;
        it.data_byte = byte_q[0];
        send(it);
        if (sb.expected_q[$].status == gld_pkg::ST_BYTE_OK) void'(byte_q.pop_front());
      end else pull();
      n++;
      if (n == pause_at) drain();
    end
    while (!(sb.phase == gld_pkg::PH_ENDED && sb.depth == 0)) pull();
    pull();
    it.opcode = gld_pkg::OpPush;
    it.data_byte = 8'($urandom);
    send(it);
    pull();
    drain();
  endtask

  task automatic write_size(int v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 1'(RegMinCodeSize);
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_size(v);
  endtask

  initial begin
    int sz;
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: missing clear, bad first code, code equal to next free, end
    pull();
    gen_start(8);
    put_code(3); put_code(256); put_code(300); put_code(256); put_code(65);
    put_code(258); put_code(255); put_code(0); put_code(259); put_code(257);
    pack_bytes();
    run_stream(6);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: sz = 15;
        1: sz = 0;
        2: sz = 8;
        3: sz = 2;
        default: sz = $urandom_range(0, 15);
      endcase
      write_size(sz);
      gen_start(sz);
      if ($urandom_range(0, 3) != 0) put_code(gen_clr);
      gen_random($urandom_range(8, 25), 50);
      pack_bytes();
      run_stream(-1);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("gif_lzw_index_decoder_core regression: pass");
    else
      $display("gif_lzw_index_decoder_core regression: fail");
    $finish;
  end
endmodule
